// ===== sv/dsfp_pkg.sv =====
package dsfp_pkg;

    // frame bytes
    localparam logic [7:0] HDR_BYTE  = 8'hAA;
    localparam logic [7:0] CMD_BYTE  = 8'hC0;
    localparam logic [7:0] TAIL_BYTE = 8'hAB;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int READ_W      = 16;
    localparam int SUM_W       = 40;
    localparam int COUNT_OUT_W = 24;

    // default width of the frame counter
    localparam int COUNT_BITS_DEF = 24;

    // statistics values after a clear, and the saturation limit of the sums
    localparam logic [READ_W-1:0] READ_MIN_INIT = '1;
    localparam logic [READ_W-1:0] READ_MAX_INIT = '0;
    localparam logic [SUM_W-1:0]  SUM_MAX       = '1;

    // byte position inside a frame
    typedef enum logic [3:0] {
        POS_HDR,
        POS_CMD,
        POS_PM25_LO,
        POS_PM25_HI,
        POS_PM10_LO,
        POS_PM10_HI,
        POS_EXTRA0,
        POS_EXTRA1,
        POS_CHECK,
        POS_TAIL
    } t_pos;

endpackage

// ===== sv/dust_sensor_frame_parser_stats.sv =====
// Frame parser for a serial particulate sensor, with running statistics.
// Input channel: one received byte per word (i_rx_byte) plus i_clear_stats,
// which clears sums, count, minima and maxima before that byte is parsed.
// A word is taken at a clock edge where i_in_valid is high and o_in_stall low.
// Output channel: one result word per input word, taken where o_out_valid is
// high and i_out_stall low. o_frame_done marks the byte that closed a good
// ten-byte frame; the other fields show readings and statistics after it.
// A word taken lands in the input register; its result is loaded into the
// result registers when they are empty or the receiver is not stalling.
// Throughput is one word per cycle unless the receiver stalls, set by the
// single pass from input to result registers (compare, 41-bit add, min/max).
// When the receiver stalls, the result holds and the input register keeps one
// more word; o_in_stall rises only when both are full and the output is
// stalled, and drops in the cycle the stall is released.
// Reset (synchronous, active low) empties both registers, returns the parser
// to the header search, clears sums and count, sets minima to 65535, maxima
// and last readings to 0.
module dust_sensor_frame_parser_stats
    import dsfp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [BYTE_W-1:0]      i_rx_byte,
    input  logic                   i_clear_stats,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_frame_done,
    output logic [READ_W-1:0]      o_pm25_reading,
    output logic [READ_W-1:0]      o_pm10_reading,
    output logic [SUM_W-1:0]       o_pm25_total,
    output logic [SUM_W-1:0]       o_pm10_total,
    output logic [READ_W-1:0]      o_pm25_lowest,
    output logic [READ_W-1:0]      o_pm25_highest,
    output logic [READ_W-1:0]      o_pm10_lowest,
    output logic [READ_W-1:0]      o_pm10_highest,
    output logic [COUNT_OUT_W-1:0] o_frames_seen
);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_clr;

    // result valid and frame flag
    logic r_out_valid;
    logic r_done;

    // parser state
    t_pos              r_pos, n_pos;
    logic [READ_W-1:0] r_pm25_part, n_pm25_part;
    logic [READ_W-1:0] r_pm10_part, n_pm10_part;
    logic [BYTE_W-1:0] r_chk, n_chk;
    logic              n_done;

    // statistics, also the result fields
    logic [READ_W-1:0]     r_pm25_last, n_pm25_last;
    logic [READ_W-1:0]     r_pm10_last, n_pm10_last;
    logic [SUM_W-1:0]      r_pm25_sum, n_pm25_sum;
    logic [SUM_W-1:0]      r_pm10_sum, n_pm10_sum;
    logic [READ_W-1:0]     r_pm25_min, n_pm25_min;
    logic [READ_W-1:0]     r_pm25_max, n_pm25_max;
    logic [READ_W-1:0]     r_pm10_min, n_pm10_min;
    logic [READ_W-1:0]     r_pm10_max, n_pm10_max;
    logic [COUNT_BITS-1:0] r_count, n_count;

    // statistics after an optional clear
    logic [SUM_W-1:0]      base_pm25_sum, base_pm10_sum;
    logic [READ_W-1:0]     base_pm25_min, base_pm25_max;
    logic [READ_W-1:0]     base_pm10_min, base_pm10_max;
    logic [COUNT_BITS-1:0] base_count;
    logic [SUM_W:0]        pm25_add, pm10_add;

    logic advance;
    logic in_take;

    // handshake
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // next frame position
    always_comb begin
        n_pos = r_pos;
        case (r_pos)
            POS_HDR:   n_pos = (r_byte == HDR_BYTE) ? POS_CMD : POS_HDR;
            POS_CMD:   n_pos = (r_byte == CMD_BYTE) ? POS_PM25_LO : POS_HDR;
            POS_CHECK: n_pos = (r_byte == r_chk) ? POS_TAIL : POS_HDR;
            POS_TAIL:  n_pos = POS_HDR;
            POS_PM25_LO, POS_PM25_HI, POS_PM10_LO, POS_PM10_HI,
            POS_EXTRA0, POS_EXTRA1: begin
                n_pos = t_pos'(r_pos + 4'd1);
            end
            default:   n_pos = POS_HDR;
        endcase
    end

    // field capture, checksum and frame flag
    always_comb begin
        n_pm25_part = r_pm25_part;
        n_pm10_part = r_pm10_part;
        n_chk       = r_chk;
        n_done      = 1'b0;
        case (r_pos)
            POS_PM25_LO: begin
                n_pm25_part = {{(READ_W-BYTE_W){1'b0}}, r_byte};
                n_chk       = r_byte;
            end
            POS_PM25_HI: n_pm25_part = {r_byte, r_pm25_part[BYTE_W-1:0]};
            POS_PM10_LO: n_pm10_part = {{(READ_W-BYTE_W){1'b0}}, r_byte};
            POS_PM10_HI: n_pm10_part = {r_byte, r_pm10_part[BYTE_W-1:0]};
            POS_TAIL:    n_done      = (r_byte == TAIL_BYTE);
            default:     n_done      = 1'b0;
        endcase
        if (r_pos inside {[POS_PM25_HI:POS_EXTRA1]}) begin
            n_chk = r_chk + r_byte;
        end
    end

    // statistics update
    always_comb begin
        base_pm25_sum = r_clr ? '0 : r_pm25_sum;
        base_pm10_sum = r_clr ? '0 : r_pm10_sum;
        base_pm25_min = r_clr ? READ_MIN_INIT : r_pm25_min;
        base_pm25_max = r_clr ? READ_MAX_INIT : r_pm25_max;
        base_pm10_min = r_clr ? READ_MIN_INIT : r_pm10_min;
        base_pm10_max = r_clr ? READ_MAX_INIT : r_pm10_max;
        base_count    = r_clr ? '0 : r_count;

        pm25_add = {1'b0, base_pm25_sum} + {{(SUM_W+1-READ_W){1'b0}}, r_pm25_part};
        pm10_add = {1'b0, base_pm10_sum} + {{(SUM_W+1-READ_W){1'b0}}, r_pm10_part};

        n_pm25_last = r_pm25_last;
        n_pm10_last = r_pm10_last;
        n_pm25_sum  = base_pm25_sum;
        n_pm10_sum  = base_pm10_sum;
        n_pm25_min  = base_pm25_min;
        n_pm25_max  = base_pm25_max;
        n_pm10_min  = base_pm10_min;
        n_pm10_max  = base_pm10_max;
        n_count     = base_count;
        if (n_done) begin
            n_pm25_last = r_pm25_part;
            n_pm10_last = r_pm10_part;
            n_pm25_sum  = pm25_add[SUM_W] ? SUM_MAX : pm25_add[SUM_W-1:0];
            n_pm10_sum  = pm10_add[SUM_W] ? SUM_MAX : pm10_add[SUM_W-1:0];
            if (r_pm25_part < base_pm25_min) n_pm25_min = r_pm25_part;
            if (r_pm25_part > base_pm25_max) n_pm25_max = r_pm25_part;
            if (r_pm10_part < base_pm10_min) n_pm10_min = r_pm10_part;
            if (r_pm10_part > base_pm10_max) n_pm10_max = r_pm10_part;
            if (!(&base_count)) n_count = base_count + 1'b1;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_byte <= i_rx_byte;
            r_clr  <= i_clear_stats;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // parser and statistics registers, loaded with each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HDR;
            r_done      <= 1'b0;
            r_pm25_last <= '0;
            r_pm10_last <= '0;
            r_pm25_sum  <= '0;
            r_pm10_sum  <= '0;
            r_pm25_min  <= READ_MIN_INIT;
            r_pm25_max  <= READ_MAX_INIT;
            r_pm10_min  <= READ_MIN_INIT;
            r_pm10_max  <= READ_MAX_INIT;
            r_count     <= '0;
        end else if (advance) begin
            r_pos       <= n_pos;
            r_done      <= n_done;
            r_pm25_last <= n_pm25_last;
            r_pm10_last <= n_pm10_last;
            r_pm25_sum  <= n_pm25_sum;
            r_pm10_sum  <= n_pm10_sum;
            r_pm25_min  <= n_pm25_min;
            r_pm25_max  <= n_pm25_max;
            r_pm10_min  <= n_pm10_min;
            r_pm10_max  <= n_pm10_max;
            r_count     <= n_count;
        end
    end

    // frame payload and checksum
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pm25_part <= n_pm25_part;
            r_pm10_part <= n_pm10_part;
            r_chk       <= n_chk;
        end
    end

    // result fields
    assign o_out_valid    = r_out_valid;
    assign o_frame_done   = r_done;
    assign o_pm25_reading = r_pm25_last;
    assign o_pm10_reading = r_pm10_last;
    assign o_pm25_total   = r_pm25_sum;
    assign o_pm10_total   = r_pm10_sum;
    assign o_pm25_lowest  = r_pm25_min;
    assign o_pm25_highest = r_pm25_max;
    assign o_pm10_lowest  = r_pm10_min;
    assign o_pm10_highest = r_pm10_max;
    assign o_frames_seen  = COUNT_OUT_W'(r_count);

endmodule
